// ----- rtl/slc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, token kind codes and byte class functions for the token classifier.
// Depends on nothing; imported by every module of the block.
package slc_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NUM,
        S_CQ1,
        S_CQ2,
        S_STR,
        S_NAME,
        S_REL,
        S_BANG
    } t_scan_state;

    localparam logic [2:0] K_ERROR  = 3'd0;
    localparam logic [2:0] K_NUMBER = 3'd1;
    localparam logic [2:0] K_CHAR   = 3'd2;
    localparam logic [2:0] K_STRING = 3'd3;
    localparam logic [2:0] K_NAME   = 3'd4;
    localparam logic [2:0] K_OP     = 3'd5;
    localparam logic [2:0] K_END    = 3'd6;

    localparam logic [7:0] B_NEWLINE = 8'd10;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] line;
        logic [11:0] start;
        logic [12:0] length;
        logic        last;
    } t_token_rec;

    typedef struct packed {
        logic [1:0] count;
        t_token_rec rec0;
        t_token_rec rec1;
    } t_scan_out;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
    endfunction

    function automatic logic is_arith(input logic [7:0] b);
        return (b == "+") || (b == "-") || (b == "*") || (b == "/");
    endfunction

    function automatic logic is_char_ok(input logic [7:0] b);
        return is_digit(b) || is_alpha(b) || is_arith(b) || (b == "_");
    endfunction

    function automatic logic is_str_ok(input logic [7:0] b);
        return (b == 8'd32) || (b == 8'd33) || ((b >= 8'd35) && (b <= 8'd126));
    endfunction

    function automatic logic is_name_mid(input logic [7:0] b);
        return (b == "_") || is_digit(b) || is_alpha(b);
    endfunction

    function automatic logic is_special(input logic [7:0] b);
        return (b == "[") || (b == "]") || (b == "(") || (b == ")") || (b == "{") ||
               (b == "}") || (b == ";") || (b == ":") || (b == ",");
    endfunction

endpackage

// ----- rtl/slc_scan_core.sv -----
`timescale 1ns / 1ps
// Scanner state, line and column counters, and per-byte token decisions.
// Depends on slc_pkg; produces up to two token records per request.
module slc_scan_core import slc_pkg::*; #(
    parameter int MAX_COLUMNS = 4096,
    parameter int MAX_LINES   = 65536
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_text,
    output t_scan_out  o_scan
);

    localparam logic [15:0] LineCap = (MAX_LINES > 65536) ? 16'hFFFF : 16'(MAX_LINES - 1);
    localparam logic [11:0] ColCap  = (MAX_COLUMNS > 4096) ? 12'hFFF : 12'(MAX_COLUMNS - 1);
    localparam logic [12:0] LenCap  = (MAX_COLUMNS > 8191) ? 13'h1FFF : 13'(MAX_COLUMNS);

    t_scan_state r_state, n_state;
    logic [15:0] r_line, n_line;
    logic        r_line_open, n_line_open;
    logic [11:0] r_col, n_col;
    logic [11:0] r_pstart, n_pstart;
    logic [12:0] r_plen, n_plen;

    logic [15:0] w_line;
    logic [11:0] w_col_plus;
    logic [12:0] w_len_plus;
    logic        w_close_valid;
    logic [2:0]  w_close_kind;
    logic        w_more;
    logic        w_adv;
    logic        w_done;
    logic [2:0]  w_done_kind;
    t_scan_state w_fresh_state;
    logic        w_fresh_emit;
    logic [2:0]  w_fresh_kind;
    logic        w_is_nl;
    logic        w_a_valid;
    logic        w_b_valid;
    t_token_rec  w_a_rec;
    t_token_rec  w_b_rec;

    // decode
    always_comb begin
        w_is_nl    = (i_text_byte == B_NEWLINE);
        w_line     = (!r_line_open && (r_line < LineCap)) ? r_line + 16'd1 : r_line;
        w_col_plus = (r_col < ColCap) ? r_col + 12'd1 : r_col;
        w_len_plus = (r_plen >= LenCap) ? LenCap : r_plen + 13'd1;

        w_close_valid = 1'b1;
        w_close_kind  = K_ERROR;
        w_more        = 1'b0;
        w_adv         = 1'b0;
        w_done        = 1'b0;
        w_done_kind   = K_OP;
        unique case (r_state)
            S_IDLE: begin
                w_close_valid = 1'b0;
            end
            S_NUM: begin
                w_close_kind = K_NUMBER;
                w_more       = is_digit(i_text_byte);
            end
            S_NAME: begin
                w_close_kind = K_NAME;
                w_more       = is_name_mid(i_text_byte);
            end
            S_STR: begin
                w_more      = is_str_ok(i_text_byte);
                w_done      = (i_text_byte == "\"");
                w_done_kind = K_STRING;
            end
            S_CQ1: begin
                w_adv = is_char_ok(i_text_byte);
            end
            S_CQ2: begin
                w_done      = (i_text_byte == "'");
                w_done_kind = K_CHAR;
            end
            S_REL: begin
                w_close_kind = K_OP;
                w_done       = (i_text_byte == "=");
            end
            S_BANG: begin
                w_done = (i_text_byte == "=");
            end
        endcase

        w_fresh_state = S_IDLE;
        w_fresh_emit  = 1'b0;
        w_fresh_kind  = K_ERROR;
        if (is_digit(i_text_byte)) begin
            w_fresh_state = S_NUM;
        end else if (i_text_byte == "'") begin
            w_fresh_state = S_CQ1;
        end else if (i_text_byte == "\"") begin
            w_fresh_state = S_STR;
        end else if ((i_text_byte == "_") || is_alpha(i_text_byte)) begin
            w_fresh_state = S_NAME;
        end else if ((i_text_byte == "<") || (i_text_byte == ">") || (i_text_byte == "=")) begin
            w_fresh_state = S_REL;
        end else if (i_text_byte == "!") begin
            w_fresh_state = S_BANG;
        end else if (is_special(i_text_byte) || is_arith(i_text_byte)) begin
            w_fresh_emit = 1'b1;
            w_fresh_kind = K_OP;
        end else if (!is_space(i_text_byte)) begin
            w_fresh_emit = 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state     = r_state;
        n_line      = r_line;
        n_line_open = r_line_open;
        n_col       = r_col;
        n_pstart    = r_pstart;
        n_plen      = r_plen;
        if (i_end_of_text) begin
            n_state     = S_IDLE;
            n_line      = '0;
            n_line_open = 1'b0;
            n_col       = '0;
            n_pstart    = '0;
            n_plen      = '0;
        end else if (w_is_nl) begin
            n_state     = S_IDLE;
            n_line      = w_line;
            n_line_open = 1'b0;
            n_col       = '0;
        end else begin
            n_line      = w_line;
            n_line_open = 1'b1;
            n_col       = w_col_plus;
            if (w_more) begin
                n_plen = w_len_plus;
            end else if (w_adv) begin
                n_plen  = w_len_plus;
                n_state = S_CQ2;
            end else if (w_done) begin
                n_state = S_IDLE;
            end else begin
                n_state = w_fresh_state;
                if (w_fresh_state != S_IDLE) begin
                    n_pstart = r_col;
                    n_plen   = 13'd1;
                end
            end
        end
    end

    // records
    always_comb begin
        w_a_valid = 1'b0;
        w_b_valid = 1'b0;
        w_a_rec   = '{kind: w_close_kind, line: w_line, start: r_pstart, length: r_plen,
                      last: 1'b0};
        w_b_rec   = '{kind: w_fresh_kind, line: w_line, start: r_col, length: 13'd1,
                      last: 1'b0};
        if (i_end_of_text) begin
            w_a_valid    = w_close_valid;
            w_a_rec.line = r_line;
            w_b_valid    = 1'b1;
            w_b_rec      = '{kind: K_END, line: r_line, start: '0, length: '0, last: 1'b0};
        end else if (w_is_nl) begin
            w_a_valid = w_close_valid;
        end else if (w_done) begin
            w_a_valid      = 1'b1;
            w_a_rec.kind   = w_done_kind;
            w_a_rec.length = w_len_plus;
        end else if (!w_more && !w_adv) begin
            w_a_valid = w_close_valid;
            w_b_valid = w_fresh_emit;
        end

        o_scan.count     = {1'b0, w_a_valid} + {1'b0, w_b_valid};
        o_scan.rec0      = w_a_valid ? w_a_rec : w_b_rec;
        o_scan.rec0.last = !(w_a_valid && w_b_valid);
        o_scan.rec1      = w_b_rec;
        o_scan.rec1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_line      <= '0;
            r_line_open <= 1'b0;
            r_col       <= '0;
            r_pstart    <= '0;
            r_plen      <= '0;
        end else if (i_step) begin
            r_state     <= n_state;
            r_line      <= n_line;
            r_line_open <= n_line_open;
            r_col       <= n_col;
            r_pstart    <= n_pstart;
            r_plen      <= n_plen;
        end
    end

endmodule

// ----- rtl/slc_result_buf.sv -----
`timescale 1ns / 1ps
// Two-entry result register that drives the output channel.
// Depends on slc_pkg; takes zero, one or two records per push.
module slc_result_buf import slc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_scan_out  i_scan,
    input  logic       i_stall,
    output logic       o_valid,
    output t_token_rec o_rec,
    output logic [1:0] o_free
);

    logic [1:0] r_cnt, n_cnt;
    t_token_rec r_slot0, n_slot0;
    t_token_rec r_slot1, n_slot1;
    logic       w_pop;
    logic [1:0] w_rem;

    assign o_valid = (r_cnt != 2'd0);
    assign o_rec   = r_slot0;
    assign w_pop   = o_valid && !i_stall;
    assign w_rem   = r_cnt - {1'b0, w_pop};
    assign o_free  = 2'd2 - w_rem;

    always_comb begin
        n_slot0 = w_pop ? r_slot1 : r_slot0;
        n_slot1 = r_slot1;
        n_cnt   = w_rem;
        if (i_push) begin
            n_cnt = w_rem + i_scan.count;
            if (w_rem == 2'd0) begin
                n_slot0 = i_scan.rec0;
                n_slot1 = i_scan.rec1;
            end else if (w_rem == 2'd1) begin
                n_slot1 = i_scan.rec0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

endmodule

// ----- rtl/source_lexer_token_classifier.sv -----
`timescale 1ns / 1ps
// Token classifier top: input register, scanner, two-entry result register.
// A request sits in the input register until the result register has room for
// its records; they are then written there and offered. Throughput: one request
// per cycle while there is room; two records leave via its single output port.
// Reset: synchronous active low; clears scanner state, counters and valid flags.
module source_lexer_token_classifier import slc_pkg::*; #(
    parameter int MAX_COLUMNS = 4096,
    parameter int MAX_LINES   = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_token_kind,
    output logic [15:0] o_line_number,
    output logic [11:0] o_start_column,
    output logic [12:0] o_token_length,
    output logic        o_last_of_run
);

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_byte;
    logic       r_eot;
    logic       w_accept;
    logic       w_process;
    logic [1:0] w_free;
    t_scan_out  w_scan;
    t_token_rec w_out_rec;

    assign w_process = r_in_valid && (w_scan.count <= w_free);
    assign o_stall   = r_in_valid && !w_process;
    assign w_accept  = i_valid && !o_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (w_process) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte <= i_text_byte;
            r_eot  <= i_end_of_text;
        end
    end

    slc_scan_core #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_LINES   (MAX_LINES)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_process),
        .i_text_byte   (r_byte),
        .i_end_of_text (r_eot),
        .o_scan        (w_scan)
    );

    slc_result_buf u_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_process),
        .i_scan  (w_scan),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_rec   (w_out_rec),
        .o_free  (w_free)
    );

    assign o_token_kind   = w_out_rec.kind;
    assign o_line_number  = w_out_rec.line;
    assign o_start_column = w_out_rec.start;
    assign o_token_length = w_out_rec.length;
    assign o_last_of_run  = w_out_rec.last;

    a_end_marker_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_token_kind == K_END)) |->
            (o_last_of_run && (o_token_length == 13'd0) && (o_start_column == 12'd0)))
        else $error("end marker record malformed");

    a_token_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_token_kind != K_END)) |-> (o_line_number != 16'd0))
        else $error("token record on line zero");

    a_held_request_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_process) |=> (r_in_valid && $stable(r_byte) && $stable(r_eot)))
        else $error("held request lost or changed");

    a_kind_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_token_kind != 3'd7))
        else $error("record kind out of range");

endmodule
